FILE: design/dab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dab_pkg;

    localparam int THETA_BINS = 2048;
    localparam int PHI_BINS   = 512;

    // Input and magnitude widths.
    localparam int XW   = 18;
    localparam int AW   = 18;
    localparam int SQW  = 36;
    // Square root: 41-bit radicand, 21-bit root, two root bits per stage.
    localparam int REMW      = 42;
    localparam int CW        = 21;
    localparam int SQ_PER    = 2;
    localparam int SQ_STAGES = (CW + SQ_PER - 1) / SQ_PER;
    // Azimuth divider: 9 quotient bits, one per stage.
    localparam int DRW = 19;
    localparam int QW  = 9;
    // Theta and phi widths.
    localparam int TW   = 11;
    localparam int PW   = 9;
    localparam int C1W  = 27;
    localparam int CSW  = 38;
    localparam int BW   = 17;

    localparam int ONE_Q20 = 1 << 20;

    localparam logic [SQW-1:0] SQ_ONE   = SQW'(64'h1_0000_0000);
    localparam logic [C1W-1:0] C100_20  = C1W'(20 * ONE_Q20);
    localparam logic [C1W-1:0] C100_75  = C1W'(75 * ONE_Q20);
    localparam logic [C1W-1:0] C100_95  = C1W'(95 * ONE_Q20);
    localparam logic [C1W-1:0] C100_99  = C1W'(99 * ONE_Q20);
    localparam logic [TW-1:0]  TH_MAX   = TW'(THETA_BINS - 1);
    localparam logic [PW-1:0]  PH_MAX   = PW'(PHI_BINS - 1);

    typedef struct packed {
        logic              out_disk;
        logic              x_zero;
        logic              swap;
        logic [REMW-1:0]   rem;
        logic [CW-1:0]     root;
        logic [DRW-1:0]    drem;
        logic [AW-1:0]     dmax;
        logic [QW-1:0]     quo;
    } root_t;

    typedef struct packed {
        logic          valid_res;
        logic [TW-1:0] theta_index;
        logic [PW-1:0] phi_index;
    } bin_t;

    // Polar bin boundary k, scaled by 102400.
    function automatic logic [BW-1:0] bound_scaled(input logic [TW:0] k);
        logic [BW-1:0] b;
        if (k <= 12'd1024)
        begin
            b = 17'd102400 - BW'(k);
        end
        else if (k <= 12'd1536)
        begin
            b = 17'd101376 - (BW'(k - 12'd1024) << 3);
        end
        else if (k <= 12'd1792)
        begin
            b = 17'd97280 - BW'(k - 12'd1536) * 17'd80;
        end
        else
        begin
            b = 17'd76800 - BW'(k - 12'd1792) * 17'd220;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: design/dab_dir_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dab_dir_if
    import dab_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] x_dir;
    logic signed [XW-1:0] y_dir;

    modport source (output valid, x_dir, y_dir, input ready);
    modport sink   (input valid, x_dir, y_dir, output ready);
endinterface

`default_nettype wire

FILE: design/dab_bin_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dab_bin_if
    import dab_pkg::*;
();
    logic          valid;
    logic          ready;
    logic          valid_res;
    logic [TW-1:0] theta_index;
    logic [PW-1:0] phi_index;

    modport source (output valid, valid_res, theta_index, phi_index, input ready);
    modport sink   (input valid, valid_res, theta_index, phi_index, output ready);
endinterface

`default_nettype wire

FILE: design/dab_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dab_front
    import dab_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [XW-1:0] x_dir,
    input  wire logic signed [XW-1:0] y_dir,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output root_t                     out_st
);

    logic [1:0]     v_reg;
    logic [2:0]     rdy;
    logic [AW-1:0]  ax_reg, ax_next;
    logic [AW-1:0]  ay_reg, ay_next;
    logic [SQW-1:0] sq_reg, sq_next;
    root_t          st_reg, st_next;
    logic [32:0]    diff;

    always_comb
    begin
        rdy[2] = out_ready;
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[1];
    assign out_st    = st_reg;

    always_comb
    begin
        ax_next = x_dir[XW-1] ? AW'(-x_dir) : AW'(x_dir);
        ay_next = y_dir[XW-1] ? AW'(-y_dir) : AW'(y_dir);
        sq_next = (SQW'(ax_next) * SQW'(ax_next)) + (SQW'(ay_next) * SQW'(ay_next));
    end

    always_comb
    begin
        diff             = 33'(SQ_ONE) - sq_reg[32:0];
        st_next.out_disk = sq_reg > SQ_ONE;
        st_next.rem      = st_next.out_disk ? '0 : {1'b0, diff, 8'b0};
        st_next.root     = '0;
        st_next.x_zero   = ax_reg == '0;
        st_next.swap     = ay_reg >= ax_reg;
        st_next.dmax     = st_next.swap ? ay_reg : ax_reg;
        st_next.drem     = DRW'(st_next.swap ? ax_reg : ay_reg);
        st_next.quo      = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (rdy[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            sq_reg <= sq_next;
        end
        if (rdy[1])
        begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dab_root_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring square root at two root bits per stage; the azimuth
// divider adds one quotient bit per stage alongside, QW bits in all.
module dab_root_div
    import dab_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire root_t  in_st,
    output logic        out_valid,
    input  wire logic   out_ready,
    output root_t       out_st
);

    logic [SQ_STAGES-1:0] v_reg;
    logic [SQ_STAGES:0]   rdy;
    logic [SQ_STAGES:0]   pv;
    root_t                pre     [SQ_STAGES+1];
    root_t                st_reg  [SQ_STAGES];
    root_t                st_next [SQ_STAGES];

    always_comb
    begin
        rdy[SQ_STAGES] = out_ready;
        for (int i = SQ_STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[SQ_STAGES-1];
    assign out_st    = st_reg[SQ_STAGES-1];
    assign pre[0]    = in_st;
    assign pv[0]     = in_valid;

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_stage
        assign pre[s+1] = st_reg[s];
        assign pv[s+1]  = v_reg[s];

        always_comb
        begin
            root_t           w;
            int              bi;
            logic [REMW-1:0] trial;
            logic [DRW-1:0]  t;
            w = pre[s];
            for (int k = 0; k < SQ_PER; k++)
            begin
                bi    = CW - 1 - SQ_PER * s - k;
                trial = (REMW'(w.root) << (bi + 1)) + (REMW'(1) << (2 * bi));
                if (bi >= 0 && w.rem >= trial)
                begin
                    w.rem      = w.rem - trial;
                    w.root[bi] = 1'b1;
                end
            end
            t = (s == 0) ? w.drem : DRW'(w.drem << 1);
            if (s < QW)
            begin
                if (t >= DRW'(w.dmax))
                begin
                    w.quo[QW-1-s] = 1'b1;
                    w.drem        = t - DRW'(w.dmax);
                end
                else
                begin
                    w.drem = t;
                end
            end
            st_next[s] = w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                v_reg[s] <= pv[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/dab_theta.sv
`timescale 1ns / 1ps
`default_nettype none

module dab_theta
    import dab_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire root_t  in_st,
    output logic        out_valid,
    input  wire logic   out_ready,
    output bin_t        out_bin
);

    typedef struct packed {
        logic           invalid;
        logic [PW-1:0]  ph_raw;
        logic [C1W-1:0] c100;
        logic [CSW-1:0] cs;
        logic [BW-1:0]  th0;
    } t1_t;

    typedef struct packed {
        logic           invalid;
        logic [PW-1:0]  ph_raw;
        logic [CSW-1:0] cs;
        logic [TW-1:0]  th;
    } t2_t;

    typedef struct packed {
        logic           invalid;
        logic [PW-1:0]  ph_raw;
        logic [CSW-1:0] cs;
        logic [TW-1:0]  th;
        logic [BW-1:0]  bl;
        logic [BW-1:0]  bh;
    } t3_t;

    logic [3:0] v_reg;
    logic [4:0] rdy;
    t1_t        s1_reg, s1_next;
    t2_t        s2_reg, s2_next;
    t3_t        s3_reg, s3_next;
    bin_t       s4_reg, s4_next;

    logic [CW-1:0]  c;
    logic [CSW-1:0] p0;
    logic [C1W-1:0] n99, n95, n75;
    logic [10:0]    a5;
    logic [14:0]    a55;
    logic [26:0]    m5;
    logic [29:0]    m55;
    logic [TW:0]    th_c;
    logic           dec, inc;
    logic [TW-1:0]  th_f;

    always_comb
    begin
        rdy[4] = out_ready;
        for (int i = 3; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_bin   = s4_reg;

    // Stage 1: scaled forms of cos(theta) and the raw azimuth bin.
    always_comb
    begin
        c               = in_st.root;
        s1_next.c100    = C1W'(c) * C1W'(100);
        s1_next.cs      = CSW'(c) * CSW'(102400);
        p0              = CSW'(CW'(ONE_Q20) - c) * CSW'(102400);
        s1_next.th0     = p0[36:20];
        s1_next.invalid = in_st.out_disk || (s1_next.c100 < C100_20);
        if (in_st.x_zero)
        begin
            s1_next.ph_raw = PH_MAX;
        end
        else if (in_st.swap)
        begin
            s1_next.ph_raw = PH_MAX - in_st.quo;
        end
        else
        begin
            s1_next.ph_raw = in_st.quo;
        end
    end

    // Stage 2: piecewise-linear first guess; /5 and /55 by reciprocal.
    always_comb
    begin
        n99 = C100_99 - s1_reg.c100;
        n95 = C100_95 - s1_reg.c100;
        n75 = C100_75 - s1_reg.c100;
        a5  = 11'(n95 >> 14);
        a55 = 15'(n75 >> 12);
        m5  = 27'(a5) * 27'd52429;
        m55 = 30'(a55) * 30'd19066;
        if (s1_reg.c100 > C100_99)
        begin
            th_c = 12'(s1_reg.th0);
        end
        else if (s1_reg.c100 > C100_95)
        begin
            th_c = 12'(n99 >> 13) + 12'd1024;
        end
        else if (s1_reg.c100 > C100_75)
        begin
            th_c = 12'(m5[26:18]) + 12'd1536;
        end
        else
        begin
            th_c = 12'(m55[29:20]) + 12'd1792;
        end
        s2_next.invalid = s1_reg.invalid;
        s2_next.ph_raw  = s1_reg.ph_raw;
        s2_next.cs      = s1_reg.cs;
        s2_next.th      = (th_c > 12'(TH_MAX)) ? TH_MAX : th_c[TW-1:0];
    end

    // Stage 3: bin boundaries on both sides of the guess.
    always_comb
    begin
        s3_next.invalid = s2_reg.invalid;
        s3_next.ph_raw  = s2_reg.ph_raw;
        s3_next.cs      = s2_reg.cs;
        s3_next.th      = s2_reg.th;
        s3_next.bl      = bound_scaled({1'b0, s2_reg.th});
        s3_next.bh      = bound_scaled({1'b0, s2_reg.th} + 12'd1);
    end

    // Stage 4: one correction step, then the on-axis and invalid cases.
    always_comb
    begin
        dec = (s3_reg.th != '0) && ({1'b0, s3_reg.bl, 20'b0} < s3_reg.cs);
        inc = !dec && (s3_reg.th != TH_MAX) && ({1'b0, s3_reg.bh, 20'b0} > s3_reg.cs);
        if (dec)
        begin
            th_f = s3_reg.th - 11'd1;
        end
        else if (inc)
        begin
            th_f = s3_reg.th + 11'd1;
        end
        else
        begin
            th_f = s3_reg.th;
        end
        if (s3_reg.invalid)
        begin
            s4_next = '0;
        end
        else
        begin
            s4_next.valid_res   = 1'b1;
            s4_next.theta_index = th_f;
            s4_next.phi_index   = (th_f == '0) ? '0 : s3_reg.ph_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < 4; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_reg <= s1_next;
        end
        if (rdy[1])
        begin
            s2_reg <= s2_next;
        end
        if (rdy[2])
        begin
            s3_reg <= s3_next;
        end
        if (rdy[3])
        begin
            s4_reg <= s4_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/direction_to_angle_bin_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Maps a direction (x and y direction cosines, signed Q1.16) to a polar bin
// (0..2047) and an azimuth bin (0..511), with valid_res low for directions
// outside the unit disk or with cos(theta) below 0.2, in which case both
// bins read zero. One request is taken every clock cycle when the output is
// not stalled. The front stages form x^2 + y^2 and the radicand, the
// square-root stages run the root at two root bits per stage (the azimuth
// quotient is built in the same stages), and the theta stages bin, correct
// and register the result. Every stage holds its own valid bit, so a
// stalled output lets requests keep entering until the empty stages are
// filled.
module direction_to_angle_bin_core
    import dab_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dab_dir_if.sink     dir,
    dab_bin_if.source   bin
);

    logic  f_valid, f_ready;
    root_t f_st;
    logic  r_valid, r_ready;
    root_t r_st;
    bin_t  res;

    dab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dir.valid),
        .in_ready  (dir.ready),
        .x_dir     (dir.x_dir),
        .y_dir     (dir.y_dir),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_st    (f_st)
    );

    dab_root_div u_root_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_st     (f_st),
        .out_valid (r_valid),
        .out_ready (r_ready),
        .out_st    (r_st)
    );

    dab_theta u_theta (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .in_st     (r_st),
        .out_valid (bin.valid),
        .out_ready (bin.ready),
        .out_bin   (res)
    );

    assign bin.valid_res   = res.valid_res;
    assign bin.theta_index = res.theta_index;
    assign bin.phi_index   = res.phi_index;

    // Requests are refused only when every stage, the output included, is full.
    a_full_when_refused: assert property (@(posedge clk) disable iff (!rst_n)
        !dir.ready |-> bin.valid)
        else $error("request refused while the output stage is empty");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        bin.valid && !bin.valid_res |-> bin.theta_index == '0 && bin.phi_index == '0)
        else $error("invalid result carries nonzero bins");

    a_on_axis: assert property (@(posedge clk) disable iff (!rst_n)
        bin.valid && bin.valid_res && bin.theta_index == '0 |-> bin.phi_index == '0)
        else $error("on-axis result has nonzero azimuth bin");

endmodule

`default_nettype wire

FILE: verif/direction_to_angle_bin_core_test.sv
`timescale 1ns / 1ps

module direction_to_angle_bin_core_test;
    import dab_pkg::*;

    logic clk;
    logic rst_n;

    dab_dir_if dir_ch ();
    dab_bin_if bin_ch ();

    direction_to_angle_bin_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .dir   (dir_ch.sink),
        .bin   (bin_ch.source)
    );

    typedef struct {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic                 known;
        bin_t                 res;
    } dir_row_t;

    bin_t   bins_due[$];
    int     errors;
    int     idle_cycles;
    bit     calm;
    bit     hold_long;
    bit     sending_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] edge_scaled(input logic [63:0] k);
        if (k <= 1024)
        begin
            return 64'd102400 - k;
        end
        if (k <= 1536)
        begin
            return 64'd101376 - 8 * (k - 1024);
        end
        if (k <= 1792)
        begin
            return 64'd97280 - 80 * (k - 1536);
        end
        return 64'd76800 - 220 * (k - 1792);
    endfunction

    function automatic logic [63:0] slope_bin(input logic [63:0] t);
        logic [63:0] k;
        k = (t + 64'd2048) / 64'd4096;
        if (k > 256)
        begin
            k = 256;
        end
        if (t < k * 4096)
        begin
            k = k - 1;
        end
        return k;
    endfunction

    function automatic bin_t predict_bins(input logic signed [XW-1:0] x,
                                          input logic signed [XW-1:0] y);
        bin_t        r;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] sq;
        logic [63:0] c;
        logic [63:0] c100;
        logic [63:0] th;
        logic [63:0] ph;
        logic [63:0] one;
        logic [63:0] t;
        r = '0;
        one = 64'd1 << 20;
        ax = (x < 0) ? 64'(-int'(x)) : 64'(int'(x));
        ay = (y < 0) ? 64'(-int'(y)) : 64'(int'(y));
        sq = ax * ax + ay * ay;
        if (sq > (64'd1 << 32))
        begin
            return r;
        end
        c = root64(((64'd1 << 32) - sq) << 8);
        c100 = 100 * c;
        if (c100 < 20 * one)
        begin
            return r;
        end
        if (c100 > 99 * one)
        begin
            th = ((one - c) * 102400) >> 20;
        end
        else if (c100 > 95 * one)
        begin
            th = (((99 * one - c100) * 128) >> 20) + 1024;
        end
        else if (c100 > 75 * one)
        begin
            th = ((95 * one - c100) * 64) / (5 * one) + 1536;
        end
        else
        begin
            th = ((75 * one - c100) * 256) / (55 * one) + 1792;
        end
        if (th > 2047)
        begin
            th = 2047;
        end
        if (th > 0 && edge_scaled(th) * one < c * 102400)
        begin
            th = th - 1;
        end
        if (th < 2047 && edge_scaled(th + 1) * one > c * 102400)
        begin
            th = th + 1;
        end
        if (th == 0)
        begin
            ph = 0;
        end
        else if (ax == 0)
        begin
            ph = 511;
        end
        else
        begin
            t = (ay << 20) / ax;
            if (t < one)
            begin
                ph = slope_bin(t);
            end
            else
            begin
                ph = 511 - slope_bin((ax << 20) / ay);
            end
        end
        r.valid_res = 1'b1;
        r.theta_index = th[TW-1:0];
        r.phi_index = ph[PW-1:0];
        return r;
    endfunction

    task automatic offer_dir(input logic signed [XW-1:0] x, input logic signed [XW-1:0] y);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            dir_ch.valid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        dir_ch.valid <= 1'b1;
        dir_ch.x_dir <= x;
        dir_ch.y_dir <= y;
        @(posedge clk);
        while (!dir_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Draws a direction mostly inside the disk, biased toward the valid cone.
    task automatic draw_dir(output logic signed [XW-1:0] x, output logic signed [XW-1:0] y);
        int m;
        case ($urandom_range(0, 7))
            0: m = 65536;
            1: m = 1024;
            2: m = 64;
            default: m = 60000;
        endcase
        x = XW'($signed($urandom_range(0, 2 * m)) - m);
        y = XW'($signed($urandom_range(0, 2 * m)) - m);
        if ($urandom_range(0, 15) == 0)
        begin
            x = XW'($urandom);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            y = XW'($urandom);
        end
        if ($urandom_range(0, 20) == 0)
        begin
            x = '0;
        end
    endtask

    initial
    begin
        dir_row_t             rows[$];
        dir_row_t             row;
        logic signed [XW-1:0] rx;
        logic signed [XW-1:0] ry;
        errors = 0;
        calm = 1'b0;
        hold_long = 1'b0;
        sending_done = 1'b0;
        dir_ch.valid = 1'b0;
        dir_ch.x_dir = '0;
        dir_ch.y_dir = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Straight up, edges of the disk, steep cutoff, zero x, and far-out codes.
        rows.push_back('{18'sd0, 18'sd0, 1'b1, '{1'b1, 11'd0, 9'd0}});
        rows.push_back('{18'sd65536, 18'sd0, 1'b1, '{1'b0, 11'd0, 9'd0}});
        rows.push_back('{-18'sd65536, 18'sd0, 1'b1, '{1'b0, 11'd0, 9'd0}});
        rows.push_back('{18'sd0, -18'sd65536, 1'b1, '{1'b0, 11'd0, 9'd0}});
        rows.push_back('{18'sd65536, 18'sd65536, 1'b1, '{1'b0, 11'd0, 9'd0}});
        rows.push_back('{18'sh1FFFF, 18'sh1FFFF, 1'b1, '{1'b0, 11'd0, 9'd0}});
        rows.push_back('{-18'sh20000, -18'sh20000, 1'b1, '{1'b0, 11'd0, 9'd0}});
        rows.push_back('{18'sd0, 18'sd1000, 1'b0, '0});
        rows.push_back('{18'sd0, -18'sd40000, 1'b0, '0});
        rows.push_back('{18'sd1, 18'sd0, 1'b0, '0});
        rows.push_back('{-18'sd1, -18'sd1, 1'b0, '0});
        rows.push_back('{18'sd1000, 18'sd1000, 1'b0, '0});
        rows.push_back('{18'sd9000, -18'sd3, 1'b0, '0});
        rows.push_back('{18'sd20000, 18'sd9000, 1'b0, '0});
        rows.push_back('{-18'sd40000, 18'sd30000, 1'b0, '0});
        rows.push_back('{18'sd64225, 18'sd0, 1'b0, '0});
        rows.push_back('{18'sd64224, 18'sd0, 1'b0, '0});
        rows.push_back('{18'sd64226, 18'sd0, 1'b0, '0});
        rows.push_back('{18'sd45000, 18'sd45000, 1'b0, '0});
        rows.push_back('{18'sd3, 18'sd50000, 1'b0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            bins_due.push_back(row.known ? row.res : predict_bins(row.x, row.y));
            offer_dir(row.x, row.y);
        end

        for (int n = 0; n < 1150; n++)
        begin
            if (n == 200)
            begin
                hold_long = 1'b1;
            end
            if (n == 1000)
            begin
                calm = 1'b1;
            end
            draw_dir(rx, ry);
            bins_due.push_back(predict_bins(rx, ry));
            offer_dir(rx, ry);
        end
        dir_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Result side: random stalls, one long hold-off, then always ready.
    initial
    begin
        int gap;
        bin_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                hold_long = 1'b0;
                bin_ch.ready <= 1'b0;
                repeat (60) @(negedge clk);
            end
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                bin_ch.ready <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                bin_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        bin_t got;
        bin_t want;
        if (rst_n && bin_ch.valid && bin_ch.ready)
        begin
            got.valid_res = bin_ch.valid_res;
            got.theta_index = bin_ch.theta_index;
            got.phi_index = bin_ch.phi_index;
            if (bins_due.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end
            else
            begin
                want = bins_due.pop_front();
                if (got.valid_res !== want.valid_res)
                begin
                    $display("%0t: valid_res expected %0d actual %0d",
                             $time, want.valid_res, got.valid_res);
                    errors++;
                end
                if (got.theta_index !== want.theta_index)
                begin
                    $display("%0t: theta_index expected %0d actual %0d",
                             $time, want.theta_index, got.theta_index);
                    errors++;
                end
                if (got.phi_index !== want.phi_index)
                begin
                    $display("%0t: phi_index expected %0d actual %0d",
                             $time, want.phi_index, got.phi_index);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (dir_ch.valid && dir_ch.ready) || (bin_ch.valid && bin_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        idle_cycles = 0;
        wait (sending_done && bins_due.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && bins_due.size() == 0)
        begin
            $display("[direction_to_angle_bin_core] OK");
        end
        else
        begin
            $display("[direction_to_angle_bin_core] ERROR");
        end
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= 2000);
        $display("%0t: no progress", $time);
        $display("[direction_to_angle_bin_core] ERROR");
        $finish;
    end

endmodule
